>>> src/mlbd_pkg.sv
// ----------------------------------------------------------------------------
// mlbd_pkg: shared types and constants of the mip level box downsampler
// Field widths, register indexes, request op codes and the queue entry type.
// ----------------------------------------------------------------------------
package mlbd_pkg;

   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   localparam int NUM_CH      = 4;
   localparam int CH_W        = 8;
   localparam int SUM_W       = 10;
   localparam int CFG_W       = 13;
   localparam int CFG_IDX_W   = 2;
   localparam int NCH_W       = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

   localparam logic OP_LINE_WRITE = 1'b0;
   localparam logic OP_EMIT       = 1'b1;

   typedef logic [NUM_CH-1:0][CH_W-1:0]  pixel_type;
   typedef logic [NUM_CH-1:0][SUM_W-1:0] pair_sum_type;

   // one classified request, handed from the front end to the back end
   typedef struct packed {
      logic                op;
      pair_sum_type        hsum;
      logic                odd_col;
      logic                odd_row;
      logic                last;
      logic [NUM_CH-1:0]   ch_en;
   } op_entry_type;

   // line buffer address width for a given maximum source width
   function automatic int line_addr_w(input int max_width);
      int depth;
      depth = (max_width + 1) / 2;
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

>>> src/mlbd_front.sv
// ----------------------------------------------------------------------------
// mlbd_front: configuration registers, raster position and pair building
// Tracks column and row, adds horizontal pixel pairs and classifies each
// request as a line buffer write, a result, or nothing.
// ----------------------------------------------------------------------------
module mlbd_front import mlbd_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int ADDR_W     = line_addr_w(DEF_MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  pixel_type             req_px,
   input  logic                  csr_valid,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   output logic                  push,
   output op_entry_type          push_entry,
   output logic [ADDR_W-1:0]     push_addr
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [WW-1:0]    width_ff, width_in;
   logic [HW-1:0]    height_ff, height_in;
   logic [NCH_W-1:0] nch_ff, nch_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   pair_sum_type     hsum_ff, hsum_in;

   logic             restart;
   logic             odd_col, odd_row, last_col, last_row;
   logic [31:0]      wval, hval;
   logic [NUM_CH-1:0] ch_en;

   assign restart = csr_valid && (csr_index == REG_SRC_WIDTH ||
                                  csr_index == REG_SRC_HEIGHT ||
                                  csr_index == REG_CHANNEL_COUNT);

   // saturate written sizes to 1..MAX
   always_comb begin
      wval = 32'(csr_wdata);
      hval = 32'(csr_wdata);
      if (wval == 32'd0) begin
         width_in = WW'(1);
      end else if (wval > 32'(MAX_WIDTH)) begin
         width_in = WW'(MAX_WIDTH);
      end else begin
         width_in = WW'(wval);
      end
      if (hval == 32'd0) begin
         height_in = HW'(1);
      end else if (hval > 32'(MAX_HEIGHT)) begin
         height_in = HW'(MAX_HEIGHT);
      end else begin
         height_in = HW'(hval);
      end
      case (csr_wdata[NCH_W-1:0])
         3'd0:                 nch_in = 3'd1;
         3'd1, 3'd2, 3'd3, 3'd4: nch_in = csr_wdata[NCH_W-1:0];
         default:              nch_in = 3'd4;
      endcase
   end

   assign odd_col  = col_ff[0];
   assign odd_row  = row_ff[0];
   assign last_col = (WW'(col_ff) + WW'(1)) == width_ff;
   assign last_row = (HW'(row_ff) + HW'(1)) == height_ff;

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         ch_en[c] = NCH_W'(c) < nch_ff;
         if (odd_col) begin
            hsum_in[c] = hsum_ff[c] + SUM_W'(req_px[c]);
         end else begin
            hsum_in[c] = SUM_W'(req_px[c]);
         end
      end
   end

   always_comb begin
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + RW'(1);
      end else begin
         col_in = col_ff + CW'(1);
         row_in = row_ff;
      end
   end

   // a pair closes on an odd column or at the right edge
   assign push               = accept && (odd_col || last_col);
   assign push_addr          = ADDR_W'(col_ff >> 1);
   assign push_entry.op      = (!odd_row && !last_row) ? OP_LINE_WRITE : OP_EMIT;
   assign push_entry.hsum    = hsum_in;
   assign push_entry.odd_col = odd_col;
   assign push_entry.odd_row = odd_row;
   assign push_entry.last    = last_col && last_row;
   assign push_entry.ch_en   = ch_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(1);
         height_ff <= HW'(1);
         nch_ff    <= 3'd3;
         col_ff    <= '0;
         row_ff    <= '0;
         hsum_ff   <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_SRC_WIDTH:     width_ff  <= width_in;
               REG_SRC_HEIGHT:    height_ff <= height_in;
               REG_CHANNEL_COUNT: nch_ff    <= nch_in;
               default:           ;
            endcase
         end
         if (restart) begin
            col_ff  <= '0;
            row_ff  <= '0;
            hsum_ff <= '0;
         end else if (accept) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            hsum_ff <= hsum_in;
         end
      end
   end

endmodule

>>> src/mlbd_queue.sv
// ----------------------------------------------------------------------------
// mlbd_queue: short request queue between front end and back end
// Register-based FIFO; lets either side stall on its own.
// ----------------------------------------------------------------------------
module mlbd_queue import mlbd_pkg::*; #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] head,
   output logic              empty,
   output logic              full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]       count_ff, count_in;

   assign empty = count_ff == '0;
   assign full  = count_ff == (PW+1)'(DEPTH);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("request pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("request popped from empty queue");
`endif

endmodule

>>> src/mlbd_back.sv
// ----------------------------------------------------------------------------
// mlbd_back: line buffer and averaging back end
// Stores upper-row pair sums, reads them back for the lower row, adds,
// shifts by the block size and holds the result in the output register.
// ----------------------------------------------------------------------------
module mlbd_back import mlbd_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int ADDR_W    = line_addr_w(DEF_MAX_WIDTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  op_entry_type       head_entry,
   input  logic [ADDR_W-1:0]  head_addr,
   input  logic               empty,
   output logic               pop,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output pixel_type          rsp_px,
   output logic               rsp_last
);

   localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

   logic [NUM_CH*SUM_W-1:0] line_mem [LINE_DEPTH];

   pair_sum_type  rd_ff;
   op_entry_type  s1_ff;
   logic          s1_valid_ff, s1_valid_in;
   logic          out_valid_ff, out_valid_in;
   pixel_type     out_px_ff, out_px_in;
   logic          out_last_ff;

   logic          out_free, s1_adv, s1_free;
   logic [SUM_W:0] line_val, sum;
   logic [1:0]     sh;
   logic [SUM_W:0] avg;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_adv   = s1_valid_ff && out_free;
   assign s1_free  = !s1_valid_ff || out_free;
   assign pop      = !empty && s1_free;

   // line buffer: write upper row pair sums, registered read for lower row
   always_ff @(posedge clock) begin
      if (pop && head_entry.op == OP_LINE_WRITE) begin
         line_mem[head_addr] <= head_entry.hsum;
      end
      if (pop) begin
         rd_ff <= line_mem[head_addr];
      end
   end

   always_comb begin
      sh = {1'b0, s1_ff.odd_col} + {1'b0, s1_ff.odd_row};
      line_val = '0;
      sum = '0;
      avg = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         line_val     = s1_ff.odd_row ? {1'b0, rd_ff[c]} : '0;
         sum          = {1'b0, s1_ff.hsum[c]} + line_val;
         avg          = sum >> sh;
         out_px_in[c] = s1_ff.ch_en[c] ? avg[CH_W-1:0] : '0;
      end
   end

   always_comb begin
      if (pop) begin
         s1_valid_in = head_entry.op == OP_EMIT;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff <= head_entry;
      end
      if (s1_adv) begin
         out_px_ff   <= out_px_in;
         out_last_ff <= s1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_px    = out_px_ff;
   assign rsp_last  = out_last_ff;

`ifndef SYNTHESIS
   a_rd_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.odd_row && !out_free |=> $stable(rd_ff))
      else $error("line read data lost while stage blocked");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |-> !pop)
      else $error("request popped into blocked stage");
`endif

endmodule

>>> src/mip_level_box_downsampler.sv
// ----------------------------------------------------------------------------
// mip_level_box_downsampler: 2x2 box filter for one mipmap level
// Raster-order source pixels in, averaged destination pixels out.
// ----------------------------------------------------------------------------
// Throughput: one source pixel per clock, sustained while the queue has room.
// Path: the request that completes a block passes the queue, the line buffer
//   read stage and the output register before its result is valid.
// Reset: clears positions, queue and valid bits; registers return to width 1,
//   height 1, three channels. The line buffer is not cleared.
module mip_level_box_downsampler import mlbd_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CH_W-1:0]      req_in_ch0,
   input  logic [CH_W-1:0]      req_in_ch1,
   input  logic [CH_W-1:0]      req_in_ch2,
   input  logic [CH_W-1:0]      req_in_ch3,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CH_W-1:0]      rsp_out_ch0,
   output logic [CH_W-1:0]      rsp_out_ch1,
   output logic [CH_W-1:0]      rsp_out_ch2,
   output logic [CH_W-1:0]      rsp_out_ch3,
   output logic                 rsp_level_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int ADDR_W = line_addr_w(MAX_WIDTH);
   localparam int Q_W    = ADDR_W + $bits(op_entry_type);

   logic              accept;
   pixel_type         req_px;
   logic              push, pop, q_empty, q_full;
   op_entry_type      push_entry, head_entry;
   logic [ADDR_W-1:0] push_addr, head_addr;
   logic [Q_W-1:0]    head_data;
   pixel_type         rsp_px;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign req_px    = {req_in_ch3, req_in_ch2, req_in_ch1, req_in_ch0};

   mlbd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_px     (req_px),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .push_entry (push_entry),
      .push_addr  (push_addr)
   );

   mlbd_queue #(
      .DATA_W (Q_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_addr, push_entry}),
      .pop       (pop),
      .head      (head_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign head_addr  = head_data[Q_W-1 -: ADDR_W];
   assign head_entry = op_entry_type'(head_data[$bits(op_entry_type)-1:0]);

   mlbd_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .head_addr  (head_addr),
      .empty      (q_empty),
      .pop        (pop),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_px     (rsp_px),
      .rsp_last   (rsp_level_last)
   );

   assign rsp_out_ch0 = rsp_px[0];
   assign rsp_out_ch1 = rsp_px[1];
   assign rsp_out_ch2 = rsp_px[2];
   assign rsp_out_ch3 = rsp_px[3];

endmodule
